FILE: rtl/wttd_pkg.sv
// ----------------------------------------------------------------------------
// Waypoint to turn and distance: shared definitions
// Number formats, CORDIC arctangent table, rounding and scaling constants,
// configuration register indexes.
// ----------------------------------------------------------------------------
package wttd_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ANGLE_FRAC   = 12;

    localparam int XY_FRAC  = 16;
    localparam int Z_FRAC   = 30;
    localparam int TAB_LEN  = 24;
    localparam int ATW      = $clog2(TAB_LEN);
    localparam int ITW      = $clog2(CORDIC_STEPS);

    localparam int COORD_W  = 12;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int XYW      = 32;
    localparam int ZW       = 35;
    localparam int HEAD_W   = 16;
    localparam int TURN_W   = HEAD_W + 1;
    localparam int ACC_W    = 2 * DIFF_W - 1;
    localparam int RLEN_W   = 31;
    localparam int OUT_W    = 16;
    localparam int MUL_W    = 32;
    localparam int PROD_W   = 2 * MUL_W;

    localparam int ZSH      = Z_FRAC - ANGLE_FRAC;
    localparam int LEN_SH   = 24;
    localparam int TURN_SH  = ANGLE_FRAC + 8;

    localparam logic signed [63:0] PI_Z64      = 64'sd3373259426;
    localparam logic signed [63:0] HALF_PI_Z64 = 64'sd1686629713;
    localparam logic signed [63:0] INV_GAIN64  = 64'sd652032874;

    localparam logic signed [ZW-1:0] PI_Z      = ZW'(PI_Z64);
    localparam logic signed [ZW-1:0] HALF_PI_Z = ZW'(HALF_PI_Z64);
    localparam logic signed [ZW-1:0] Z_RND     = ZW'(64'sd1 <<< (ZSH - 1));

    localparam logic signed [63:0] PI_Q64 =
        (PI_Z64 + (64'sd1 <<< (ZSH - 1))) >>> ZSH;
    localparam logic signed [63:0] HALF_PI_Q64 =
        (HALF_PI_Z64 + (64'sd1 <<< (ZSH - 1))) >>> ZSH;

    localparam logic signed [TURN_W-1:0] PI_Q      = TURN_W'(PI_Q64);
    localparam logic signed [TURN_W-1:0] TWO_PI_Q  = TURN_W'(2 * PI_Q64);
    localparam logic signed [HEAD_W-1:0] HEAD_INIT = HEAD_W'(HALF_PI_Q64);

    localparam logic signed [MUL_W-1:0] INV_GAIN = MUL_W'(INV_GAIN64);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_STEP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_SCALE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_SCALE   = 2'd2;

    localparam logic [7:0]  MIN_STEP_RST     = 8'd5;
    localparam logic [15:0] LENGTH_SCALE_RST = 16'd1792;
    localparam logic [15:0] TURN_SCALE_RST   = 16'd52677;

    // arctan(2^-k) in radians, Q30
    function automatic logic signed [ZW-1:0] atan_z(input logic [ATW-1:0] k);
        logic signed [ZW-1:0] v;
        unique case (k)
            5'd0:    v = ZW'(64'sd843314857);
            5'd1:    v = ZW'(64'sd497837829);
            5'd2:    v = ZW'(64'sd263043837);
            5'd3:    v = ZW'(64'sd133525159);
            5'd4:    v = ZW'(64'sd67021687);
            5'd5:    v = ZW'(64'sd33543516);
            5'd6:    v = ZW'(64'sd16775851);
            5'd7:    v = ZW'(64'sd8388437);
            5'd8:    v = ZW'(64'sd4194283);
            5'd9:    v = ZW'(64'sd2097149);
            5'd10:   v = ZW'(64'sd1048576);
            5'd11:   v = ZW'(64'sd524288);
            5'd12:   v = ZW'(64'sd262144);
            5'd13:   v = ZW'(64'sd131072);
            5'd14:   v = ZW'(64'sd65536);
            5'd15:   v = ZW'(64'sd32768);
            5'd16:   v = ZW'(64'sd16384);
            5'd17:   v = ZW'(64'sd8192);
            5'd18:   v = ZW'(64'sd4096);
            5'd19:   v = ZW'(64'sd2048);
            5'd20:   v = ZW'(64'sd1024);
            5'd21:   v = ZW'(64'sd512);
            5'd22:   v = ZW'(64'sd256);
            5'd23:   v = ZW'(64'sd128);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/waypoint_to_turn_and_distance.sv
// ----------------------------------------------------------------------------
// Waypoint to turn and distance
// Drops waypoints too near the last kept one; for each kept point gives the
// segment length and turn angle in wheel steps from one CORDIC vectoring pass
// and one shared multiplier.
// ----------------------------------------------------------------------------
// Kept point: squares (skipped for the first point), CORDIC pass, heading fix,
//   length and turn scaling, then the result is offered and the next item taken.
// Dropped point: next item taken after the three multiplier steps.
// Rate is set by the CORDIC iteration loop, the shared 32x32 multiplier and output stalls.
// Synchronous active-low reset restores config defaults, heading +pi/2,
//   last point at origin and the first-point flag.
module waypoint_to_turn_and_distance (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [11:0]                i_x_mm,
    input  logic signed [11:0]                i_y_mm,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [15:0]                       o_length_steps,
    output logic signed [15:0]                o_turn_steps,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [wttd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [wttd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import wttd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SQX, S_SQY, S_SQM, S_INIT, S_ITER,
        S_FIX, S_LEN1, S_LEN2, S_TURN, S_OUT
    } t_state;

    t_state                    r_state;
    logic [7:0]                r_min_step;
    logic [15:0]               r_length_scale;
    logic [15:0]               r_turn_scale;
    logic signed [COORD_W-1:0] r_last_x;
    logic signed [COORD_W-1:0] r_last_y;
    logic signed [HEAD_W-1:0]  r_last_heading;
    logic                      r_first;
    logic signed [COORD_W-1:0] r_px;
    logic signed [COORD_W-1:0] r_py;
    logic signed [DIFF_W-1:0]  r_dx;
    logic signed [DIFF_W-1:0]  r_dy;
    logic [ACC_W-1:0]          r_acc;
    logic signed [XYW-1:0]     r_x;
    logic signed [XYW-1:0]     r_y;
    logic signed [ZW-1:0]      r_z;
    logic [ITW-1:0]            r_iter;
    logic signed [HEAD_W-1:0]  r_heading;
    logic signed [TURN_W-1:0]  r_turn;
    logic [RLEN_W-1:0]         r_len;
    logic [OUT_W-1:0]          r_len_res;
    logic signed [OUT_W-1:0]   r_turn_res;

    logic                      in_acc;
    logic signed [DIFF_W-1:0]  in_dx;
    logic signed [DIFF_W-1:0]  in_dy;
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [XYW-1:0]     x0;
    logic signed [XYW-1:0]     y0;
    logic signed [XYW-1:0]     xs;
    logic signed [XYW-1:0]     ys;
    logic signed [XYW-1:0]     n_x;
    logic signed [XYW-1:0]     n_y;
    logic signed [ZW-1:0]      n_z;
    logic signed [ZW-1:0]      z_fix;
    logic signed [ZW-1:0]      z_rnd;
    logic signed [TURN_W-1:0]  turn_raw;
    logic signed [TURN_W-1:0]  turn_a;
    logic signed [TURN_W-1:0]  n_turn;
    logic signed [PROD_W-1:0]  len_sum;
    logic signed [PROD_W-1:0]  turn_sum;
    logic [OUT_W-1:0]          n_len_res;
    logic signed [OUT_W-1:0]   n_turn_res;
    logic                      out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign in_dx       = DIFF_W'(i_x_mm) - DIFF_W'(r_last_x);
    assign in_dy       = DIFF_W'(i_y_mm) - DIFF_W'(r_last_y);
    assign out_free    = !o_out_valid || !i_out_stall;

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_SQX: begin
                mul_a = MUL_W'(r_dx);
                mul_b = MUL_W'(r_dx);
            end
            S_SQY: begin
                mul_a = MUL_W'(r_dy);
                mul_b = MUL_W'(r_dy);
            end
            S_SQM: begin
                mul_a = MUL_W'(r_min_step);
                mul_b = MUL_W'(r_min_step);
            end
            S_LEN1: begin
                mul_a = r_x[XYW-1] ? '0 : r_x;
                mul_b = INV_GAIN;
            end
            S_LEN2: begin
                mul_a = MUL_W'(r_len);
                mul_b = MUL_W'(r_length_scale);
            end
            S_TURN: begin
                mul_a = MUL_W'(r_turn);
                mul_b = MUL_W'(r_turn_scale);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // CORDIC step and start vector
    always_comb begin
        x0 = XYW'(r_dx) <<< XY_FRAC;
        y0 = XYW'(r_dy) <<< XY_FRAC;
        xs = r_x >>> r_iter;
        ys = r_y >>> r_iter;
        if (!r_y[XYW-1]) begin
            n_x = r_x + ys;
            n_y = r_y - xs;
            n_z = r_z + atan_z(ATW'(r_iter));
        end else begin
            n_x = r_x - ys;
            n_y = r_y + xs;
            n_z = r_z - atan_z(ATW'(r_iter));
        end
    end

    // axis overrides and heading rounding
    always_comb begin
        priority if (r_dx == '0) begin
            z_fix = (r_dy > 0) ? HALF_PI_Z : -HALF_PI_Z;
        end else if (r_dy == '0) begin
            z_fix = (r_dx > 0) ? '0 : PI_Z;
        end else begin
            z_fix = r_z;
        end
        z_rnd = (z_fix + Z_RND) >>> ZSH;
    end

    // turn wrap into (-pi, pi]
    always_comb begin
        turn_raw = TURN_W'(r_heading) - TURN_W'(r_last_heading);
        turn_a   = (turn_raw > PI_Q) ? turn_raw - TWO_PI_Q : turn_raw;
        n_turn   = (turn_a <= -PI_Q) ? turn_a + TWO_PI_Q : turn_a;
    end

    // rounding and saturation of scaled results
    always_comb begin
        len_sum  = (prod + (PROD_W'(1) <<< (LEN_SH - 1))) >>> LEN_SH;
        turn_sum = (prod + (PROD_W'(1) <<< (TURN_SH - 1))) >>> TURN_SH;
        n_len_res = (len_sum > PROD_W'(65535)) ? 16'hFFFF : OUT_W'(len_sum);
        priority if (turn_sum > PROD_W'(32767)) begin
            n_turn_res = 16'sh7FFF;
        end else if (turn_sum < -PROD_W'(32768)) begin
            n_turn_res = -16'sh8000;
        end else begin
            n_turn_res = OUT_W'(turn_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_min_step     <= MIN_STEP_RST;
            r_length_scale <= LENGTH_SCALE_RST;
            r_turn_scale   <= TURN_SCALE_RST;
            r_last_x       <= '0;
            r_last_y       <= '0;
            r_last_heading <= HEAD_INIT;
            r_first        <= 1'b1;
            r_iter         <= '0;
            o_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_MIN_STEP:     r_min_step     <= i_cfg_data[7:0];
                    CFG_LENGTH_SCALE: r_length_scale <= i_cfg_data;
                    CFG_TURN_SCALE:   r_turn_scale   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_OUT && out_free) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_px    <= i_x_mm;
                        r_py    <= i_y_mm;
                        r_dx    <= in_dx;
                        r_dy    <= in_dy;
                        r_state <= r_first ? S_INIT : S_SQX;
                    end
                end
                S_SQX: begin
                    r_acc   <= ACC_W'(prod);
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_acc   <= r_acc + ACC_W'(prod);
                    r_state <= S_SQM;
                end
                S_SQM: begin
                    // drop the point when inside the minimum step
                    r_state <= (r_acc < ACC_W'(prod)) ? S_IDLE : S_INIT;
                end
                S_INIT: begin
                    r_iter <= '0;
                    if (r_dx < 0) begin
                        r_x <= -x0;
                        r_y <= -y0;
                        r_z <= (r_dy >= 0) ? PI_Z : -PI_Z;
                    end else begin
                        r_x <= x0;
                        r_y <= y0;
                        r_z <= '0;
                    end
                    r_state <= S_ITER;
                end
                S_ITER: begin
                    r_x    <= n_x;
                    r_y    <= n_y;
                    r_z    <= n_z;
                    r_iter <= r_iter + 1'b1;
                    if (r_iter == ITW'(CORDIC_STEPS - 1)) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    r_heading <= HEAD_W'(z_rnd);
                    r_state   <= S_LEN1;
                end
                S_LEN1: begin
                    r_len   <= RLEN_W'(prod >>> Z_FRAC);
                    r_turn  <= n_turn;
                    r_state <= S_LEN2;
                end
                S_LEN2: begin
                    r_len_res <= n_len_res;
                    r_state   <= S_TURN;
                end
                S_TURN: begin
                    r_turn_res     <= n_turn_res;
                    r_last_x       <= r_px;
                    r_last_y       <= r_py;
                    r_last_heading <= r_heading;
                    r_first        <= 1'b0;
                    r_state        <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        o_length_steps <= r_len_res;
                        o_turn_steps   <= r_turn_res;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state != S_IDLE)
        else $error("accepted item left the block idle");

    a_iter_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ITER && r_iter == ITW'(CORDIC_STEPS - 1)) |=> r_state == S_FIX)
        else $error("CORDIC pass did not end after the last iteration");

    a_turn_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_TURN |-> (r_turn <= PI_Q && r_turn > -PI_Q))
        else $error("turn outside (-pi, pi]");

    a_first_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_first) |-> $past(r_state) == S_TURN)
        else $error("first-point flag cleared outside commit");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_OUT)
        else $error("result offered without a finished item");

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Waypoint to turn and distance testbench
// Streams directed and random waypoints through the block under several
// register settings and idling patterns, predicts each kept segment with a
// local CORDIC vectoring model and checks length and turn field by field.
// ----------------------------------------------------------------------------
module tb;

    import wttd_pkg::*;

    typedef struct packed {
        logic signed [11:0] x;
        logic signed [11:0] y;
    } t_waypoint;

    typedef struct packed {
        logic [15:0]        length;
        logic signed [15:0] turn;
    } t_segment;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int     WATCHDOG_LIMIT = 5000;
    localparam int     SETTLE_CYCLES  = 40;
    localparam int     LONG_HOLD      = 300;
    localparam longint Z_PI           = 64'sd3373259426;
    localparam longint Z_HALF_PI      = 64'sd1686629713;
    localparam longint GAIN_INV_Q30   = 64'sd652032874;
    localparam longint ATAN_Q30 [0:23] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128
    };

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic signed [11:0]     i_x_mm = '0;
    logic signed [11:0]     i_y_mm = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic [15:0]            o_length_steps;
    logic signed [15:0]     o_turn_steps;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    t_waypoint waypoint_q[$];
    t_segment  segment_q[$];

    logic [7:0]  min_step;
    logic [15:0] length_scale;
    logic [15:0] turn_scale;
    longint      kept_x;
    longint      kept_y;
    longint      kept_heading;
    bit          first_pending;

    int  src_idle_pct = 25;
    int  sink_idle_pct = 87;
    int  errors = 0;
    int  idle_cycles = 0;
    int  hold_left = 0;
    bit  long_hold_done = 1'b0;
    int  walk_x = 0;
    int  walk_y = 0;

    waypoint_to_turn_and_distance dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_x_mm         (i_x_mm),
        .i_y_mm         (i_y_mm),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_length_steps (o_length_steps),
        .o_turn_steps   (o_turn_steps),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic longint to_angle(input longint z);
        return (z + (64'sd1 <<< (Z_FRAC - ANGLE_FRAC - 1))) >>> (Z_FRAC - ANGLE_FRAC);
    endfunction

    function automatic void plan_segment(input logic signed [11:0] px,
                                         input logic signed [11:0] py);
        longint   dx, dy, x, y, z, xs, ys, m, r, len, heading, pi_q, turn, t, ls, ts;
        t_segment seg;
        dx = longint'(px) - kept_x;
        dy = longint'(py) - kept_y;
        m  = min_step;
        ls = length_scale;
        ts = turn_scale;
        if (!first_pending && (dx * dx + dy * dy < m * m)) begin
            return;
        end
        x = dx <<< XY_FRAC;
        y = dy <<< XY_FRAC;
        z = 0;
        if (dx < 0) begin
            z = (dy >= 0) ? Z_PI : -Z_PI;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_Q30[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_Q30[i];
            end
        end
        if (dx == 0) begin
            z = (dy > 0) ? Z_HALF_PI : -Z_HALF_PI;
        end else if (dy == 0) begin
            z = (dx > 0) ? 0 : Z_PI;
        end
        heading = to_angle(z);

        r   = (x > 0) ? x : 0;
        r   = (r * GAIN_INV_Q30) >>> 30;
        len = (r * ls + (64'sd1 <<< 23)) >>> 24;
        if (len > 65535) begin
            len = 65535;
        end

        pi_q = to_angle(Z_PI);
        turn = heading - kept_heading;
        if (turn > pi_q) begin
            turn = turn - 2 * pi_q;
        end
        if (turn <= -pi_q) begin
            turn = turn + 2 * pi_q;
        end
        t = (turn * ts + (64'sd1 <<< (ANGLE_FRAC + 7))) >>> (ANGLE_FRAC + 8);
        if (t > 32767) begin
            t = 32767;
        end
        if (t < -32768) begin
            t = -32768;
        end

        kept_x        = px;
        kept_y        = py;
        kept_heading  = heading;
        first_pending = 1'b0;
        seg.length = len[15:0];
        seg.turn   = t[15:0];
        segment_q.push_back(seg);
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        $display("mismatch at %0t ns: %s", $time, what);
    endtask

    // Driver: hold the item while stalled, advance only when free.
    always @(posedge i_clk) begin : drive_waypoints
        t_waypoint pt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                plan_segment(i_x_mm, i_y_mm);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (waypoint_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    pt = waypoint_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_x_mm     <= pt.x;
                    i_y_mm     <= pt.y;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare against the oldest expected segment.
    always @(posedge i_clk) begin : check_segments
        t_segment seg;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (segment_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected segment len %0d turn %0d",
                                              o_length_steps, o_turn_steps));
                end else begin
                    seg = segment_q.pop_front();
                    if (o_length_steps !== seg.length) begin
                        report_mismatch($sformatf("length %0d, expected %0d",
                                                  o_length_steps, seg.length));
                    end
                    if (o_turn_steps !== seg.turn) begin
                        report_mismatch($sformatf("turn %0d, expected %0d",
                                                  o_turn_steps, seg.turn));
                    end
                end
                if (src_idle_pct == 0 && !long_hold_done) begin
                    long_hold_done = 1'b1;
                    hold_left = LONG_HOLD;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < sink_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        case (idx)
            CFG_MIN_STEP:     min_step = val[7:0];
            CFG_LENGTH_SCALE: length_scale = val;
            CFG_TURN_SCALE:   turn_scale = val;
            default:          ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic push_point(input int x, input int y);
        t_waypoint pt;
        pt.x = 12'(x);
        pt.y = 12'(y);
        waypoint_q.push_back(pt);
        walk_x = x;
        walk_y = y;
    endtask

    // Mostly short walks around the drop distance, plus moves of up to 300 per axis,
    // axis moves, repeats and jumps anywhere in the field.
    task automatic queue_walk(input int count);
        int kind, r, dx, dy, nx, ny;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(99);
            r    = min_step + 3;
            dx   = 0;
            dy   = 0;
            if (kind < 55) begin
                dx = $urandom_range(2 * r) - r;
                dy = $urandom_range(2 * r) - r;
            end else if (kind < 70) begin
                dx = $urandom_range(600) - 300;
                dy = $urandom_range(600) - 300;
            end else if (kind < 80) begin
                if ($urandom_range(1)) begin
                    dx = $urandom_range(1, 600) * ($urandom_range(1) ? 1 : -1);
                end else begin
                    dy = $urandom_range(1, 600) * ($urandom_range(1) ? 1 : -1);
                end
            end
            nx = walk_x + dx;
            ny = walk_y + dy;
            if (kind >= 88) begin
                nx = int'($urandom_range(4095)) - 2048;
                ny = int'($urandom_range(4095)) - 2048;
            end
            nx = (nx > 2047) ? 2047 : ((nx < -2048) ? -2048 : nx);
            ny = (ny > 2047) ? 2047 : ((ny < -2048) ? -2048 : ny);
            push_point(nx, ny);
        end
    endtask

    task automatic wait_drained();
        while (waypoint_q.size() != 0 || i_in_valid || segment_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        min_step      = MIN_STEP_RST;
        length_scale  = LENGTH_SCALE_RST;
        turn_scale    = TURN_SCALE_RST;
        kept_x        = 0;
        kept_y        = 0;
        kept_heading  = to_angle(Z_HALF_PI);
        first_pending = 1'b1;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: first point, drop boundary, axes, quadrants, extremes
        push_point(0, 0);
        push_point(0, 0);
        push_point(3, 4);
        push_point(5, 5);
        push_point(2047, 4);
        push_point(-2048, 4);
        push_point(-2048, 2047);
        push_point(-2048, -2048);
        push_point(2047, 2047);
        push_point(-2048, -2048);
        push_point(2047, -2000);
        push_point(-2048, 2047);
        push_point(-100, -5);
        push_point(-105, -5);
        push_point(-108, -9);
        push_point(-104, -6);
        push_point(-100, -9);
        push_point(-97, -12);
        push_point(-97, -12);
        wait_drained();

        write_reg(CFG_MIN_STEP, 16'hAB00);
        write_reg(CFG_LENGTH_SCALE, 16'hFFFF);
        write_reg(CFG_TURN_SCALE, 16'hFFFF);
        write_reg(CFG_UNUSED, 16'h1234);
        queue_walk(80);
        wait_drained();

        write_reg(CFG_MIN_STEP, 16'h55FF);
        write_reg(CFG_LENGTH_SCALE, 16'h0000);
        write_reg(CFG_TURN_SCALE, 16'h0000);
        src_idle_pct  = 87;
        sink_idle_pct = 25;
        queue_walk(60);
        wait_drained();

        write_reg(CFG_MIN_STEP, 16'(MIN_STEP_RST));
        write_reg(CFG_LENGTH_SCALE, LENGTH_SCALE_RST);
        write_reg(CFG_TURN_SCALE, TURN_SCALE_RST);
        queue_walk(50);
        wait_drained();
        queue_walk(50);
        wait_drained();

        write_reg(CFG_MIN_STEP, 16'($urandom_range(40)));
        write_reg(CFG_LENGTH_SCALE, 16'($urandom));
        write_reg(CFG_TURN_SCALE, 16'($urandom));
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        queue_walk(120);
        wait_drained();

        if (segment_q.size() != 0) begin
            report_mismatch($sformatf("%0d segments never arrived", segment_q.size()));
        end
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/wttd_pkg.sv
rtl/waypoint_to_turn_and_distance.sv
test/tb.sv
